// ===== hdl/hsvh_pkg.sv =====
// Package: shared types, constants and functions of the HSV color histogram.
`timescale 1ns / 1ps
package hsvh_pkg;
   localparam int IGNORE_ENTRIES_DEF = 8;
   localparam int COUNT_BITS_DEF     = 24;
   localparam int NUM_BINS           = 176;
   localparam int BIN_BITS           = 8;
   localparam int FIELD_BITS         = 24;
   localparam int FRAC_BITS          = 17;
   localparam int SLOT_BITS          = 3;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_IGNORE = 2'd1;
   localparam logic [1:0] REQ_PIXEL  = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  entry_index;
      logic        entry_valid;
      logic [23:0] ignore_color;
      logic [7:0]  bin_select;
   } req_type_type;

   typedef struct packed {
      logic [7:0]  bin_index;
      logic [23:0] bin_count;
      logic [23:0] pixel_total;
      logic [16:0] bin_fraction;
   } rsp_type_type;

   // Divider control between top level and divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   function automatic logic [BIN_BITS-1:0] classify(input logic [7:0] r,
         input logic [7:0] g, input logic [7:0] b);
      logic [7:0]  mx, mn, c;
      logic [1:0]  s, v;
      logic [3:0]  h;
      logic [10:0] hc;
      logic [17:0] x;
      logic [18:0] c19;
      logic [14:0] c100, m100;
      logic [12:0] m8;
      logic [13:0] m40;
      logic [14:0] m75;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      c100 = 15'(c) * 15'd100;
      m100 = 15'(mx) * 15'd100;
      m8 = 13'(mx) * 13'd8;
      m40 = 14'(mx) * 14'd40;
      m75 = 15'(mx) * 15'd75;
      s = 2'd0;
      if (c != 8'd0) begin
         if (c100 < 15'(m8)) s = 2'd0;
         else if (c100 < 15'(m40)) s = 2'd1;
         else if (c100 < m75) s = 2'd2;
         else s = 2'd3;
      end
      if (m100 < 15'd1530) v = 2'd0;
      else if (m100 < 15'd10200) v = 2'd1;
      else if (m100 < 15'd20910) v = 2'd2;
      else v = 2'd3;
      if (r == mx) begin
         hc = (g == mn) ? 11'(c) * 11'd5 + 11'(mx - b) : 11'(c) - 11'(mx - g);
      end else if (g == mx) begin
         hc = (b == mn) ? 11'(c) + 11'(mx - r) : 11'(c) * 11'd3 - 11'(mx - b);
      end else begin
         hc = (r == mn) ? 11'(c) * 11'd3 + 11'(mx - g) : 11'(c) * 11'd5 - 11'(mx - r);
      end
      x = 18'(hc) * 18'd100;
      c19 = 19'(c);
      if (c == 8'd0) begin
         if (m100 < 15'd5100) h = 4'd8;
         else if (v == 2'd3) h = 4'd9;
         else h = 4'd10;
      end else if (19'(x) < c19 * 19'd38 || 19'(x) >= c19 * 19'd525) h = 4'd0;
      else if (19'(x) < c19 * 19'd83) h = 4'd1;
      else if (19'(x) < c19 * 19'd125) h = 4'd2;
      else if (19'(x) < c19 * 19'd258) h = 4'd3;
      else if (19'(x) < c19 * 19'd325) h = 4'd4;
      else if (19'(x) < c19 * 19'd458) h = 4'd5;
      else if (19'(x) < c19 * 19'd483) h = 4'd6;
      else h = 4'd7;
      return {h, s, v};
   endfunction
endpackage

// ===== hdl/hsvh_stream_if.sv =====
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
interface hsvh_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/hsv_quantized_color_histogram.sv =====
// Top level: HSV quantized color histogram over a bin memory.
//  channel | dir | payload
//  req     | in  | req_type, red, green, blue, entry_index, entry_valid, ignore_color, bin_select
//  rsp     | out | bin_index, bin_count, pixel_total, bin_fraction
// Pixel and ignore items: one per cycle while no clear sweep or read is in progress,
// bin memory read-modify-write over two stages with forwarding of the bin being
// written. Clear: one bin a cycle; the same sweep runs after reset. Read: the bit-serial
// divider forms the fraction once any pixel item still in the pipeline has drained.
// A held result blocks new items only after a read.
`timescale 1ns / 1ps
module hsv_quantized_color_histogram #(
   parameter int IGNORE_ENTRIES = hsvh_pkg::IGNORE_ENTRIES_DEF,
   parameter int COUNT_BITS     = hsvh_pkg::COUNT_BITS_DEF
) (
   input logic clock,
   input logic reset,
   hsvh_stream_if.sink   req,
   hsvh_stream_if.source rsp
);
   import hsvh_pkg::*;
   localparam logic [2:0] ST_CLEAR = 3'd0, ST_RUN = 3'd1, ST_RD = 3'd2,
                          ST_DIV = 3'd3, ST_OUT = 3'd4;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [2:0] state_ff, state_in;
   logic [BIN_BITS-1:0] clr_ff, clr_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [FIELD_BITS-1:0] icolor_ff [IGNORE_ENTRIES];
   logic [IGNORE_ENTRIES-1:0] ien_ff;
   logic s1_ff, s1_in;
   logic [BIN_BITS-1:0] s1_bin_ff, s1_bin_in;
   logic s2_ff;
   logic [BIN_BITS-1:0] s2_bin_ff;
   logic [COUNT_BITS-1:0] s2_val_ff, cur, inc;
   logic [BIN_BITS-1:0] sel_ff, sel_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic div_start;
   div_ctl_type dctl;
   logic [FRAC_BITS-1:0] frac;
   rsp_type_type out_ff, out_in;
   req_type_type p;
   logic take, ignored, pix;
   logic mem_we;
   logic [BIN_BITS-1:0] mem_wa, rd_addr;
   logic [COUNT_BITS-1:0] mem_wd;

   assign p = req.payload;
   assign req.ready = (state_ff == ST_RUN);
   assign take = req.valid && req.ready;

   always_comb begin
      ignored = 1'b0;
      for (int k = 0; k < IGNORE_ENTRIES; k++)
         if (ien_ff[k] && icolor_ff[k] == {p.red, p.green, p.blue}) ignored = 1'b1;
   end
   assign pix = take && p.req_type == REQ_PIXEL;

   assign cur = (s2_ff && s2_bin_ff == s1_bin_ff) ? s2_val_ff : rdata_ff;
   assign inc = (cur != CMAX) ? cur + COUNT_BITS'(1) : cur;

   function automatic logic [FIELD_BITS-1:0] cap(input logic [COUNT_BITS-1:0] v);
      if (COUNT_BITS > FIELD_BITS && v > COUNT_BITS'(24'hFFFFFF)) return 24'hFFFFFF;
      return FIELD_BITS'(v);
   endfunction

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; total_in = total_ff;
      s1_in = pix && !ignored; s1_bin_in = classify(p.red, p.green, p.blue);
      sel_in = sel_ff; cnt_in = cnt_ff; div_start = 1'b0; out_in = out_ff;
      rd_addr = s1_bin_in;
      mem_we = s1_ff; mem_wa = s1_bin_ff; mem_wd = inc;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1; mem_wa = clr_ff; mem_wd = '0; s1_in = 1'b0;
            clr_in = clr_ff + BIN_BITS'(1);
            if (clr_ff == BIN_BITS'(NUM_BINS - 1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (take) begin
               unique case (p.req_type)
                  REQ_CLEAR: begin
                     total_in = '0; clr_in = '0; state_in = ST_CLEAR;
                  end
                  REQ_PIXEL: if (total_ff != CMAX) total_in = total_ff + COUNT_BITS'(1);
                  REQ_READ: if (p.bin_select < BIN_BITS'(NUM_BINS)) begin
                     sel_in = p.bin_select; state_in = ST_RD;
                  end
                  default: ;
               endcase
            end
            rd_addr = (take && p.req_type == REQ_READ) ? p.bin_select : s1_bin_in;
         end
         ST_RD: begin
            rd_addr = sel_ff;
            if (!s1_ff && !s2_ff) begin
               cnt_in = rdata_ff; div_start = 1'b1; state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dctl.done) begin
               out_in.bin_index = sel_ff; out_in.bin_count = cap(cnt_ff);
               out_in.pixel_total = cap(total_ff); out_in.bin_fraction = frac;
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (rsp.ready) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (mem_we) mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; total_ff <= '0; ien_ff <= '0;
         s1_ff <= 1'b0; s2_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; total_ff <= total_in;
         s1_ff <= s1_in; s2_ff <= s1_ff;
         for (int k = 0; k < IGNORE_ENTRIES; k++)
            if (take && p.req_type == REQ_IGNORE && 32'(p.entry_index) == k)
               ien_ff[k] <= p.entry_valid;
      end
      for (int k = 0; k < IGNORE_ENTRIES; k++)
         if (take && p.req_type == REQ_IGNORE && 32'(p.entry_index) == k)
            icolor_ff[k] <= p.ignore_color;
      s1_bin_ff <= s1_bin_in; s2_bin_ff <= s1_bin_ff; s2_val_ff <= inc;
      sel_ff <= sel_in; cnt_ff <= cnt_in; out_ff <= out_in;
   end

   hsvh_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .count(cnt_in),
      .total(total_ff), .ctl(dctl), .fraction(frac));

   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.payload = out_ff;
endmodule

// ===== hdl/hsvh_divider.sv =====
// Divider: restoring division for the Q1.16 bin fraction, one bit per cycle.
`timescale 1ns / 1ps
module hsvh_divider #(
   parameter int COUNT_BITS = hsvh_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [COUNT_BITS-1:0]         count,
   input  logic [COUNT_BITS-1:0]         total,
   output hsvh_pkg::div_ctl_type         ctl,
   output logic [hsvh_pkg::FRAC_BITS-1:0] fraction
);
   import hsvh_pkg::*;
   localparam int NB = COUNT_BITS + 16;
   localparam int SB = $clog2(NB + 1);
   logic [NB-1:0]         quo_ff, quo_in;
   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [SB-1:0]         step_ff, step_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [COUNT_BITS:0]   trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[COUNT_BITS-1:0], quo_ff[NB-1]};
      if (start) begin
         quo_in = {count, 16'd0}; rem_in = '0; den_in = total;
         step_in = SB'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         step_in = step_ff - SB'(1);
         if (step_ff == SB'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; step_ff <= step_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   always_comb begin
      if (den_ff == '0) fraction = '0;
      else if (quo_ff > NB'(65536)) fraction = 17'h10000;
      else fraction = quo_ff[FRAC_BITS-1:0];
   end
endmodule

// ===== hdl/hsvh_checker.sv =====
// Checker: port-level properties of the histogram, bound to the top level.
`timescale 1ns / 1ps
module hsvh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input hsvh_pkg::rsp_type_type rsp_payload
);
   import hsvh_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item taken while result pending");
   a_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.bin_index < 8'd176) else $error("bad bin index");
   a_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.bin_fraction <= 17'h10000) else $error("bad fraction");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("ready during clearing sweep");
endmodule

bind hsv_quantized_color_histogram hsvh_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));

// ===== tb/sv/testbench.sv =====
// Testbench for the HSV quantized color histogram: predicted bins checked on readout.
`timescale 1ns / 1ps
module testbench;
   import hsvh_pkg::*;

   logic clock;
   logic reset;
   hsvh_stream_if #(.payload_type(req_type_type)) req_ch (.clock(clock));
   hsvh_stream_if #(.payload_type(rsp_type_type)) rsp_ch (.clock(clock));

   hsv_quantized_color_histogram dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source));

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 300;

   logic [23:0]  hist_bins [NUM_BINS];
   logic [23:0]  pixel_count;
   logic [23:0]  skip_colors [8];
   logic         skip_on [8];
   bit           skip_written [8];
   rsp_type_type readout_queue [$];
   int           fail_count = 0;
   int           send_idle_pct;
   int           recv_idle_pct;
   longint       cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] predict_bin(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int mx, mn, c, hc, x, s, v, h;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      s = 0;
      if (c != 0) begin
         if (100 * c < 8 * mx) s = 0;
         else if (100 * c < 40 * mx) s = 1;
         else if (100 * c < 75 * mx) s = 2;
         else s = 3;
      end
      if (100 * mx < 6 * 255) v = 0;
      else if (100 * mx < 40 * 255) v = 1;
      else if (100 * mx < 82 * 255) v = 2;
      else v = 3;
      if (c == 0) begin
         if (100 * mx < 20 * 255) h = 8;
         else if (v == 3) h = 9;
         else h = 10;
      end else begin
         if (r == mx) hc = (g == mn) ? 5 * c + (mx - b) : c - (mx - g);
         else if (g == mx) hc = (b == mn) ? c + (mx - r) : 3 * c - (mx - b);
         else hc = (r == mn) ? 3 * c + (mx - g) : 5 * c - (mx - r);
         x = 100 * hc;
         if (x < 38 * c || x >= 525 * c) h = 0;
         else if (x < 83 * c) h = 1;
         else if (x < 125 * c) h = 2;
         else if (x < 258 * c) h = 3;
         else if (x < 325 * c) h = 4;
         else if (x < 458 * c) h = 5;
         else if (x < 483 * c) h = 6;
         else h = 7;
      end
      return 8'(h * 16 + s * 4 + v);
   endfunction

   function automatic void update_histogram(req_type_type it);
      rsp_type_type rd;
      logic [23:0]  color;
      bit           skipped;
      logic [7:0]   bin;
      case (it.req_type)
         REQ_CLEAR: begin
            foreach (hist_bins[k]) hist_bins[k] = '0;
            pixel_count = '0;
         end
         REQ_IGNORE: begin
            skip_colors[it.entry_index] = it.ignore_color;
            skip_on[it.entry_index] = it.entry_valid;
            skip_written[it.entry_index] = 1'b1;
         end
         REQ_PIXEL: begin
            if (pixel_count != 24'hFFFFFF) pixel_count = pixel_count + 1;
            color = {it.red, it.green, it.blue};
            skipped = 0;
            for (int k = 0; k < 8; k++)
               if (skip_on[k] && skip_colors[k] == color) skipped = 1;
            if (!skipped) begin
               bin = predict_bin(it.red, it.green, it.blue);
               if (hist_bins[bin] != 24'hFFFFFF) hist_bins[bin] = hist_bins[bin] + 1;
            end
         end
         default: begin
            if (it.bin_select < NUM_BINS) begin
               rd.bin_index = it.bin_select;
               rd.bin_count = hist_bins[it.bin_select];
               rd.pixel_total = pixel_count;
               rd.bin_fraction = (pixel_count == 0) ? 17'd0 :
                  17'((64'(hist_bins[it.bin_select]) << 16) / 64'(pixel_count));
               readout_queue.push_back(rd);
            end
         end
      endcase
   endfunction

   task automatic send_item(req_type_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      update_histogram(it);
   endtask

   function automatic req_type_type random_fields();
      req_type_type it;
      it = req_type_type'($bits(req_type_type)'({$urandom, $urandom}));
      return it;
   endfunction

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type_type it;
      it = random_fields();
      it.req_type = REQ_PIXEL;
      it.red = r; it.green = g; it.blue = b;
      send_item(it);
   endtask

   task automatic send_read(logic [7:0] sel);
      req_type_type it;
      it = random_fields();
      it.req_type = REQ_READ;
      it.bin_select = sel;
      send_item(it);
   endtask

   task automatic send_ignore(logic [2:0] slot, logic en, logic [23:0] color);
      req_type_type it;
      it = random_fields();
      it.req_type = REQ_IGNORE;
      it.entry_index = slot; it.entry_valid = en; it.ignore_color = color;
      send_item(it);
   endtask

   task automatic send_clear();
      req_type_type it;
      it = random_fields();
      it.req_type = REQ_CLEAR;
      send_item(it);
   endtask

   always @(posedge clock) begin
      rsp_type_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (readout_queue.size() == 0) begin
               $error("unexpected result bin_index=%0d", got.bin_index);
               fail_count++;
            end else begin
               want = readout_queue.pop_front();
               if (got.bin_index !== want.bin_index) begin
                  $error("bin_index exp %0d got %0d", want.bin_index, got.bin_index);
                  fail_count++;
               end
               if (got.bin_count !== want.bin_count) begin
                  $error("bin_count exp %0d got %0d", want.bin_count, got.bin_count);
                  fail_count++;
               end
               if (got.pixel_total !== want.pixel_total) begin
                  $error("pixel_total exp %0d got %0d", want.pixel_total, got.pixel_total);
                  fail_count++;
               end
               if (got.bin_fraction !== want.bin_fraction) begin
                  $error("bin_fraction exp %0d got %0d", want.bin_fraction,
                     got.bin_fraction);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_directed();
      send_read(8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd40, 8'd40, 8'd40);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_ignore(3'd7, 1'b1, 24'hFF0000);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_ignore(3'd7, 1'b0, 24'hFF0000);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_read(8'd3);
      send_read(8'd175);
      send_read(8'd176);
      send_read(8'd255);
      send_read(8'd163);
      send_clear();
      send_read(8'd3);
   endtask

   task automatic test_random(int count);
      req_type_type it;
      int           pick;
      for (int n = 0; n < count; n++) begin
         it = random_fields();
         pick = $urandom_range(99);
         if (pick < 1) it.req_type = REQ_CLEAR;
         else if (pick < 6) it.req_type = REQ_IGNORE;
         else if (pick < 80) it.req_type = REQ_PIXEL;
         else it.req_type = REQ_READ;
         if (it.req_type == REQ_PIXEL && $urandom_range(3) == 0) begin
            pick = $urandom_range(7);
            if (skip_written[pick])
               {it.red, it.green, it.blue} = skip_colors[pick];
            else
               it.green = it.red;
         end
         if (it.req_type == REQ_READ && $urandom_range(9) != 0)
            it.bin_select = 8'($urandom_range(NUM_BINS - 1));
         send_item(it);
      end
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (readout_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (hist_bins[k]) hist_bins[k] = '0;
      pixel_count = '0;
      foreach (skip_on[k]) begin
         skip_on[k] = 0; skip_colors[k] = '0; skip_written[k] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 6; recv_idle_pct = 77;
      test_directed();
      test_random(550);
      send_idle_pct = 77; recv_idle_pct = 6;
      test_random(500);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(550);
      wait_drain();
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
